[hw/rtl/vertex_normal_accumulator_assert.svh]
// Assertion macros for the vertex normal accumulator.
// Expects signals clk and arst_n in the including scope.
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define VNA_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define VNA_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[hw/rtl/vna_pkg.sv]
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int ADDR_W = $clog2(VERTEX_COUNT);
	localparam int IDX_W = 10;
	localparam int POS_W = 32;
	localparam int NRM_W = 16;
	localparam int CMP_W = 31; // unitizer input component, magnitude < 2^30

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_FACE = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]              func;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        second_index;
		logic [IDX_W-1:0]        third_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} vna_cmd_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    index_error;
	} vna_res_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} vna_pos_t;

	typedef struct packed {
		logic signed [CMP_W-1:0] x;
		logic signed [CMP_W-1:0] y;
		logic signed [CMP_W-1:0] z;
	} vna_vec_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} vna_nrm_t;

	function automatic logic idx_bad(input logic [IDX_W-1:0] i);
		return 32'(i) >= 32'(VERTEX_COUNT);
	endfunction

endpackage

[hw/rtl/vna_cross.sv]
// Face normal direction: edges, exact cross product on one shared multiplier,
// then a one-bit-per-cycle right shift until all magnitudes are below 2^30. Uses vna_pkg.
module vna_cross import vna_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  vna_pos_t p0,
	input  vna_pos_t p1,
	input  vna_pos_t p2,
	output logic     done,
	output vna_vec_t cvec
);

	typedef enum logic [1:0] {CR_IDLE, CR_MUL, CR_SHIFT} cr_state_t;

	cr_state_t state_q;
	logic [2:0] cnt_q;
	logic signed [32:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p, prod_q, first_q;
	logic signed [66:0] diff;
	logic [66:0] diff_abs;
	logic [65:0] mx_q, my_q, mz_q;
	logic negx_q, negy_q, negz_q;
	logic too_wide;

	always_comb begin
		case (cnt_q)
			3'd0: begin mul_a = e1y_q; mul_b = e2z_q; end
			3'd1: begin mul_a = e1z_q; mul_b = e2y_q; end
			3'd2: begin mul_a = e1z_q; mul_b = e2x_q; end
			3'd3: begin mul_a = e1x_q; mul_b = e2z_q; end
			3'd4: begin mul_a = e1x_q; mul_b = e2y_q; end
			default: begin mul_a = e1y_q; mul_b = e2x_q; end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign diff = {first_q[65], first_q} - {prod_q[65], prod_q};
	assign diff_abs = diff[66] ? 67'(-diff) : 67'(diff);
	assign too_wide = (|mx_q[65:30]) | (|my_q[65:30]) | (|mz_q[65:30]);

	assign cvec.x = negx_q ? -CMP_W'(mx_q[29:0]) : CMP_W'(mx_q[29:0]);
	assign cvec.y = negy_q ? -CMP_W'(my_q[29:0]) : CMP_W'(my_q[29:0]);
	assign cvec.z = negz_q ? -CMP_W'(mz_q[29:0]) : CMP_W'(mz_q[29:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				CR_IDLE: begin
					if (go) begin
						e1x_q <= {p1.x[31], p1.x} - {p0.x[31], p0.x};
						e1y_q <= {p1.y[31], p1.y} - {p0.y[31], p0.y};
						e1z_q <= {p1.z[31], p1.z} - {p0.z[31], p0.z};
						e2x_q <= {p2.x[31], p2.x} - {p0.x[31], p0.x};
						e2y_q <= {p2.y[31], p2.y} - {p0.y[31], p0.y};
						e2z_q <= {p2.z[31], p2.z} - {p0.z[31], p0.z};
						cnt_q <= '0;
						state_q <= CR_MUL;
					end
				end
				CR_MUL: begin
					// product k lands in prod_q in the following cycle
					if (cnt_q != 3'd6) prod_q <= mul_p;
					case (cnt_q)
						3'd1, 3'd3, 3'd5: first_q <= prod_q;
						3'd2: begin mx_q <= diff_abs[65:0]; negx_q <= diff[66]; end
						3'd4: begin my_q <= diff_abs[65:0]; negy_q <= diff[66]; end
						3'd6: begin mz_q <= diff_abs[65:0]; negz_q <= diff[66]; end
						default: ;
					endcase
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) state_q <= CR_SHIFT;
				end
				CR_SHIFT: begin
					if (too_wide) begin
						mx_q <= mx_q >> 1;
						my_q <= my_q >> 1;
						mz_q <= mz_q >> 1;
					end else begin
						done <= 1'b1;
						state_q <= CR_IDLE;
					end
				end
				default: state_q <= CR_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/vna_unitize.sv]
// Iterative unit-vector scaler: sum of squares, bit-pair square root,
// then one restoring divide step per cycle per component. Uses vna_pkg.
module vna_unitize import vna_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  vna_vec_t vec,
	output logic     done,
	output vna_nrm_t nrm
);

	typedef enum logic [2:0] {U_IDLE, U_SQ, U_ROOT, U_DINIT, U_DIV} u_state_t;

	u_state_t state_q;
	logic [1:0] cnt_q;
	logic [3:0] step_q;
	logic [2:0][29:0] mag_q;
	logic [2:0] neg_q;
	logic [29:0] sel_mag;
	logic sel_neg;
	logic [59:0] sq_q;
	logic [61:0] len2_q, len2_sum, x_q;
	logic [62:0] res_q, bit_q;
	logic [63:0] rb;
	logic root_ge;
	logic [46:0] rem_q, dsh_q;
	logic div_ge;
	logic [15:0] q_q, q_next;
	logic [2:0][NRM_W-1:0] nrm_q;
	logic signed [CMP_W-1:0] ax, ay, az;

	always_comb begin
		case (cnt_q)
			2'd0: begin sel_mag = mag_q[0]; sel_neg = neg_q[0]; end
			2'd1: begin sel_mag = mag_q[1]; sel_neg = neg_q[1]; end
			default: begin sel_mag = mag_q[2]; sel_neg = neg_q[2]; end
		endcase
	end

	assign ax = vec.x[CMP_W-1] ? -vec.x : vec.x;
	assign ay = vec.y[CMP_W-1] ? -vec.y : vec.y;
	assign az = vec.z[CMP_W-1] ? -vec.z : vec.z;

	assign len2_sum = len2_q + 62'(sq_q);
	assign rb = {1'b0, res_q} + {1'b0, bit_q};
	assign root_ge = {2'b00, x_q} >= rb;
	assign div_ge = rem_q >= dsh_q;
	assign q_next = {q_q[14:0], div_ge};

	assign nrm.x = nrm_q[0];
	assign nrm.y = nrm_q[1];
	assign nrm.z = nrm_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (go) begin
						mag_q[0] <= ax[29:0];
						mag_q[1] <= ay[29:0];
						mag_q[2] <= az[29:0];
						neg_q <= {vec.z[CMP_W-1], vec.y[CMP_W-1], vec.x[CMP_W-1]};
						len2_q <= '0;
						sq_q <= '0;
						cnt_q <= '0;
						state_q <= U_SQ;
					end
				end
				U_SQ: begin
					if (cnt_q != 2'd3) sq_q <= sel_mag * sel_mag;
					if (cnt_q != 2'd0) len2_q <= len2_sum;
					if (cnt_q == 2'd3) begin
						if (len2_sum == '0) begin
							nrm_q <= '0;
							done <= 1'b1;
							state_q <= U_IDLE;
						end else begin
							x_q <= len2_sum;
							res_q <= '0;
							bit_q <= 63'(1) << 62;
							state_q <= U_ROOT;
						end
					end
					cnt_q <= cnt_q + 2'd1;
				end
				U_ROOT: begin
					if (root_ge) begin
						x_q <= x_q - rb[61:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 63'd1) begin
						cnt_q <= '0;
						state_q <= U_DINIT;
					end
				end
				U_DINIT: begin
					// numerator m*2^15 + len, divisor 2*len aligned to quotient bit 15
					rem_q <= 47'({sel_mag, 15'b0}) + 47'(res_q[30:0]);
					dsh_q <= {res_q[30:0], 16'b0};
					q_q <= '0;
					step_q <= '0;
					state_q <= U_DIV;
				end
				U_DIV: begin
					if (div_ge) rem_q <= rem_q - dsh_q;
					q_q <= q_next;
					dsh_q <= dsh_q >> 1;
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						nrm_q[cnt_q] <= sel_neg ? -q_next : q_next;
						if (cnt_q == 2'd2) begin
							done <= 1'b1;
							state_q <= U_IDLE;
						end else begin
							cnt_q <= cnt_q + 2'd1;
							state_q <= U_DINIT;
						end
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/vertex_normal_accumulator.sv]
// Top level: position and normal memories, item sequencer, result register.
// Uses vna_pkg, vna_cross, vna_unitize and vertex_normal_accumulator_assert.svh.
//
//  channel   ports                        accepted when
//  --------  ---------------------------  ------------------------------
//  item in   start, busy, cmd             rising edge with start & !busy
//  result    result_strobe, result        rising edge ending strobe cycle
//
// Load, ignored and out-of-range items leave busy low; a read holds busy through
// T_RDOUT and its result shows in the cycle where busy drops back.
// A face holds busy to fetch the corners, form the cross product and shift it right
// until it fits in 30 bits, run the shared unitizer (square root, then divide steps
// per component) once for the face and once per corner, and read and sum each corner.
// A zero vector skips the root and divide steps of a unitizer run.
// After reset a clearing pass zeroes the normal memory, one entry a cycle, with busy high.
// The receiver cannot stall: a result is on the ports for exactly one cycle.
module vertex_normal_accumulator import vna_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  vna_cmd_t cmd,
	output logic     result_strobe,
	output vna_res_t result
);

	typedef enum logic [3:0] {
		T_CLEAR, T_IDLE, T_RDOUT, T_FRD0, T_FRD1, T_FRD2, T_FCAP,
		T_CROSS, T_FUNIT, T_ARD, T_ASUM, T_AUNIT
	} top_state_t;

	top_state_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0] i0_q, i1_q, i2_q;
	logic [1:0] corner_q;
	logic [IDX_W-1:0] corner_idx;

	// memories (positions have no reset; normals are swept clear)
	logic [3*POS_W-1:0] pmem [VERTEX_COUNT];
	logic [3*NRM_W-1:0] nmem [VERTEX_COUNT];
	logic [3*POS_W-1:0] prd_q;
	logic [3*NRM_W-1:0] nrd_q;
	logic [ADDR_W-1:0] paddr, naddr, nwaddr;
	logic nwe;
	logic [3*NRM_W-1:0] nwdata;

	vna_pos_t p0_q, p1_q, p2_q;
	vna_nrm_t fn_q, nrd;
	vna_vec_t unit_vec_q, cvec, sum;
	vna_nrm_t unit_nrm;
	logic cross_go_q, cross_done, unit_go_q, unit_done;

	logic accept, cmd_err, load_we;

	assign accept = start && !busy;
	assign busy = (state_q != T_IDLE);
	assign cmd_err = idx_bad(cmd.first_index) ||
		(cmd.func == FUNC_FACE && (idx_bad(cmd.second_index) || idx_bad(cmd.third_index)));
	assign load_we = accept && cmd.func == FUNC_LOAD && !cmd_err;

	always_comb begin
		case (corner_q)
			2'd0: corner_idx = i0_q;
			2'd1: corner_idx = i1_q;
			default: corner_idx = i2_q;
		endcase
	end

	always_comb begin
		case (state_q)
			T_FRD0: paddr = ADDR_W'(i0_q);
			T_FRD1: paddr = ADDR_W'(i1_q);
			T_FRD2: paddr = ADDR_W'(i2_q);
			default: paddr = ADDR_W'(cmd.first_index);
		endcase
	end

	assign naddr = (state_q == T_IDLE) ? ADDR_W'(cmd.first_index) : ADDR_W'(corner_idx);
	assign nwe = (state_q == T_CLEAR) || (state_q == T_AUNIT && unit_done);
	assign nwaddr = (state_q == T_CLEAR) ? clr_q : ADDR_W'(corner_idx);
	assign nwdata = (state_q == T_CLEAR) ? '0 : {unit_nrm.x, unit_nrm.y, unit_nrm.z};

	assign nrd.x = nrd_q[3*NRM_W-1:2*NRM_W];
	assign nrd.y = nrd_q[2*NRM_W-1:NRM_W];
	assign nrd.z = nrd_q[NRM_W-1:0];

	// stored normal plus face normal, each within +-16384
	assign sum.x = CMP_W'(nrd.x) + CMP_W'(fn_q.x);
	assign sum.y = CMP_W'(nrd.y) + CMP_W'(fn_q.y);
	assign sum.z = CMP_W'(nrd.z) + CMP_W'(fn_q.z);

	always_ff @(posedge clk) begin
		if (load_we) pmem[ADDR_W'(cmd.first_index)] <= {cmd.pos_x, cmd.pos_y, cmd.pos_z};
		prd_q <= pmem[paddr];
	end

	always_ff @(posedge clk) begin
		if (nwe) nmem[nwaddr] <= nwdata;
		nrd_q <= nmem[naddr];
	end

	vna_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cross_go_q),
		.p0     (p0_q),
		.p1     (p1_q),
		.p2     (p2_q),
		.done   (cross_done),
		.cvec   (cvec)
	);

	vna_unitize u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (unit_go_q),
		.vec    (unit_vec_q),
		.done   (unit_done),
		.nrm    (unit_nrm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_CLEAR;
			clr_q <= '0;
			corner_q <= '0;
			cross_go_q <= 1'b0;
			unit_go_q <= 1'b0;
			result_strobe <= 1'b0;
			result <= '0;
		end else begin
			result_strobe <= 1'b0;
			cross_go_q <= 1'b0;
			unit_go_q <= 1'b0;
			unique case (state_q)
				T_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(VERTEX_COUNT - 1)) state_q <= T_IDLE;
				end
				T_IDLE: begin
					if (accept && cmd.func != FUNC_NONE) begin
						i0_q <= cmd.first_index;
						i1_q <= cmd.second_index;
						i2_q <= cmd.third_index;
						if (cmd_err) begin
							result <= '{normal_x: '0, normal_y: '0, normal_z: '0,
								index_error: 1'b1};
							result_strobe <= 1'b1;
						end else if (cmd.func == FUNC_READ) begin
							state_q <= T_RDOUT;
						end else if (cmd.func == FUNC_FACE) begin
							state_q <= T_FRD0;
						end
					end
				end
				T_RDOUT: begin
					result <= '{normal_x: nrd.x, normal_y: nrd.y, normal_z: nrd.z,
						index_error: 1'b0};
					result_strobe <= 1'b1;
					state_q <= T_IDLE;
				end
				T_FRD0: state_q <= T_FRD1;
				T_FRD1: begin
					p0_q <= prd_q;
					state_q <= T_FRD2;
				end
				T_FRD2: begin
					p1_q <= prd_q;
					state_q <= T_FCAP;
				end
				T_FCAP: begin
					p2_q <= prd_q;
					cross_go_q <= 1'b1;
					state_q <= T_CROSS;
				end
				T_CROSS: begin
					if (cross_done) begin
						unit_vec_q <= cvec;
						unit_go_q <= 1'b1;
						state_q <= T_FUNIT;
					end
				end
				T_FUNIT: begin
					if (unit_done) begin
						fn_q <= unit_nrm;
						corner_q <= '0;
						state_q <= T_ARD;
					end
				end
				T_ARD: state_q <= T_ASUM;
				T_ASUM: begin
					unit_vec_q <= sum;
					unit_go_q <= 1'b1;
					state_q <= T_AUNIT;
				end
				T_AUNIT: begin
					// write-back happens this edge; a repeated corner rereads it
					if (unit_done) begin
						corner_q <= corner_q + 2'd1;
						state_q <= (corner_q == 2'd2) ? T_IDLE : T_ARD;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

`include "vertex_normal_accumulator_assert.svh"

	`VNA_AST_NOW(a_err_zero, result_strobe && result.index_error, result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0, "error result carries a normal")
	`VNA_AST_NEXT(a_face_busy, accept && cmd.func == FUNC_FACE && !cmd_err, busy && !result_strobe, "face item did not start")
	`VNA_AST_NOW(a_read_result, $past(accept && cmd.func == FUNC_READ && !cmd_err, 2), result_strobe && !result.index_error, "read item gave no result")
	`VNA_AST_NOW(a_norm_range, result_strobe, result.normal_x <= 16384 && result.normal_x >= -16384 && result.normal_z <= 16384 && result.normal_z >= -16384, "normal out of range")

endmodule

[bench/vertex_normal_accumulator_test.sv]
// Self-checking bench for vertex_normal_accumulator: directed table, then random mesh traffic.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
module vertex_normal_accumulator_test import vna_pkg::*;;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	vna_cmd_t cmd = '0;
	logic     result_strobe;
	vna_res_t result;

	vertex_normal_accumulator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .result_strobe(result_strobe), .result(result)
	);

	always #4 clk = ~clk;

	// shadow copy of the block's memories
	logic signed [31:0] pos_mem [VERTEX_COUNT][3];
	bit                 pos_loaded [VERTEX_COUNT];
	logic signed [15:0] nrm_mem [VERTEX_COUNT][3];

	vna_res_t normal_queue [$];
	int       fail_count = 0;
	int       sender_idle_pct = 0;

	// round(c * 16384 / |c|), halves away from zero; zero vector stays zero
	function automatic void unit_vec(input longint c [3], output logic signed [15:0] n [3]);
		longint unsigned m [3];
		longint unsigned len2, len, rem, rb, q;
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = c[i] < 0 ? -c[i] : c[i];
			len2 += m[i] * m[i];
		end
		if (len2 == 0) begin
			n[0] = '0; n[1] = '0; n[2] = '0;
			return;
		end
		// integer square root, floor
		rem = len2; len = 0; rb = 64'd1 << 62;
		while (rb > rem) rb >>= 2;
		while (rb != 0) begin
			if (rem >= len + rb) begin
				rem -= len + rb;
				len = (len >> 1) + rb;
			end else begin
				len >>= 1;
			end
			rb >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 32768 + len) / (2 * len);
			n[i] = c[i] < 0 ? -16'(q) : 16'(q);
		end
	endfunction

	// face normal from an exact cross product, scaled down below 2^30
	function automatic void face_dir(input int a, input int b, input int d,
			output logic signed [15:0] n [3]);
		logic signed [67:0] e1 [3], e2 [3], cr [3];
		longint             c [3];
		int                 top, s;
		for (int i = 0; i < 3; i++) begin
			e1[i] = 68'(pos_mem[b][i]) - 68'(pos_mem[a][i]);
			e2[i] = 68'(pos_mem[d][i]) - 68'(pos_mem[a][i]);
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		top = 0;
		for (int i = 0; i < 3; i++) begin
			logic [67:0] mg;
			mg = cr[i] < 0 ? -cr[i] : cr[i];
			for (int k = 0; k < 68; k++) if (mg[k] && k + 1 > top) top = k + 1;
		end
		s = top > 30 ? top - 30 : 0;
		for (int i = 0; i < 3; i++) begin
			logic [67:0] mg;
			mg = (cr[i] < 0 ? -cr[i] : cr[i]) >> s;
			c[i] = cr[i] < 0 ? -longint'(mg) : longint'(mg);
		end
		unit_vec(c, n);
	endfunction

	// apply one accepted item to the shadow state, queue any expected result
	task automatic predict_item(input vna_cmd_t it);
		vna_res_t r;
		logic signed [15:0] fn [3], nn [3];
		longint c [3];
		int idx [3];
		bit err;
		r = '0;
		if (it.func == FUNC_NONE) return;
		err = idx_bad(it.first_index);
		if (it.func == FUNC_FACE)
			err = err || idx_bad(it.second_index) || idx_bad(it.third_index);
		if (err) begin
			r.index_error = 1'b1;
			normal_queue.insert(normal_queue.size(), r);
			return;
		end
		case (it.func)
			FUNC_LOAD: begin
				pos_mem[it.first_index][0] = it.pos_x;
				pos_mem[it.first_index][1] = it.pos_y;
				pos_mem[it.first_index][2] = it.pos_z;
				pos_loaded[it.first_index] = 1'b1;
			end
			FUNC_FACE: begin
				idx[0] = int'(it.first_index);
				idx[1] = int'(it.second_index);
				idx[2] = int'(it.third_index);
				face_dir(idx[0], idx[1], idx[2], fn);
				for (int k = 0; k < 3; k++) begin
					for (int i = 0; i < 3; i++) c[i] = longint'(nrm_mem[idx[k]][i]) + fn[i];
					unit_vec(c, nn);
					for (int i = 0; i < 3; i++) nrm_mem[idx[k]][i] = nn[i];
				end
			end
			default: begin
				r.normal_x = nrm_mem[it.first_index][0];
				r.normal_y = nrm_mem[it.first_index][1];
				r.normal_z = nrm_mem[it.first_index][2];
				normal_queue.insert(normal_queue.size(), r);
			end
		endcase
	endtask

	// result checker; strobe cannot be stalled
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (normal_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, result);
				fail_count++;
			end else begin
				vna_res_t want;
				want = normal_queue.pop_front();
				if (result.normal_x !== want.normal_x || result.normal_y !== want.normal_y ||
						result.normal_z !== want.normal_z ||
						result.index_error !== want.index_error) begin
					$display("%0t: mismatch expected %0d %0d %0d err %0b, got %0d %0d %0d err %0b",
						$time, want.normal_x, want.normal_y, want.normal_z, want.index_error,
						result.normal_x, result.normal_y, result.normal_z, result.index_error);
					fail_count++;
				end
			end
		end
	end

	// hand one item over; start held until the edge that accepts it
	task automatic send_item(input vna_cmd_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(it);
	endtask

	function automatic vna_cmd_t mk(input logic [1:0] f, input int a, input int b, input int d,
			input int x, input int y, input int z);
		vna_cmd_t it;
		it.func = f;
		it.first_index = IDX_W'(a);
		it.second_index = IDX_W'(b);
		it.third_index = IDX_W'(d);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		return it;
	endfunction

	function automatic int rnd_loaded();
		int v;
		do v = $urandom_range(31); while (!pos_loaded[v]);
		return v;
	endfunction

	typedef struct {
		vna_cmd_t cmd;
		bit       typed;   // expected result written in the row
		vna_res_t want;
	} row_t;

	row_t rows [$];

	task automatic add_row(input vna_cmd_t c, input bit t, input vna_res_t w);
		row_t rw;
		rw.cmd = c;
		rw.typed = t;
		rw.want = w;
		rows.insert(rows.size(), rw);
	endtask

	initial begin : stimulus
		vna_cmd_t it;
		vna_res_t z;
		int r;
		z = '0;
		for (int v = 0; v < VERTEX_COUNT; v++) begin
			pos_loaded[v] = 0;
			for (int i = 0; i < 3; i++) begin
				nrm_mem[v][i] = '0;
				pos_mem[v][i] = '0;
			end
		end
		// directed: reset value, extremes, degenerate and repeated corners
		add_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(FUNC_READ, 1023, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_LOAD, 1, 0, 0, 32'h7fffffff, 32'h80000000, 0), 0, z);
		add_row(mk(FUNC_LOAD, 2, 0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff), 0, z);
		add_row(mk(FUNC_LOAD, 1023, 1023, 1023, -1, -1, -1), 0, z);
		add_row(mk(FUNC_FACE, 0, 1, 2, 0, 0, 0), 0, z);
		add_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_READ, 1, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_FACE, 0, 0, 1, 0, 0, 0), 0, z);      // degenerate face
		add_row(mk(FUNC_FACE, 1023, 2, 1023, 0, 0, 0), 0, z); // corner repeated
		add_row(mk(FUNC_FACE, 2, 1, 0, 0, 0, 0), 0, z);      // opposite winding
		add_row(mk(FUNC_READ, 2, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_READ, 1023, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_NONE, 1023, 1023, 1023, -1, -1, -1), 0, z);
		add_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(FUNC_LOAD, 3, 0, 0, 65536, 0, 0), 0, z);
		add_row(mk(FUNC_LOAD, 4, 0, 0, 0, 65536, 0), 0, z);
		add_row(mk(FUNC_FACE, 0, 3, 4, 0, 0, 0), 0, z);
		add_row(mk(FUNC_READ, 3, 0, 0, 0, 0, 0), 0, z);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[k]) begin
			send_item(rows[k].cmd);
			if (rows[k].typed) begin
				// the row's own value is what the block must return
				if (normal_queue.size() == 0) begin
					$display("%0t: row %0d expected %h, got no result queued",
						$time, k, rows[k].want);
					fail_count++;
				end else begin
					if (normal_queue[$] !== rows[k].want) begin
						$display("%0t: row %0d expected %h, predictor gave %h",
							$time, k, rows[k].want, normal_queue[$]);
						fail_count++;
					end
					normal_queue[$] = rows[k].want;
				end
			end
		end

		// random traffic: phases of sender idling; mostly loads, faces and reads on a small set
		for (int n = 0; n < 450; n++) begin
			case (n / 113)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 46;
				2: sender_idle_pct = 0;
				default: sender_idle_pct = 28;
			endcase
			r = $urandom_range(99);
			if (r < 25) begin
				it = mk(FUNC_LOAD, $urandom_range(31), 0, 0, $urandom, $urandom, $urandom);
				if ($urandom_range(3) == 0) begin
					it.pos_x = $signed($urandom_range(2000)) - 1000;
					it.pos_y = $signed($urandom_range(2000)) - 1000;
				end
			end else if (r < 50) begin
				it = mk(FUNC_FACE, rnd_loaded(), rnd_loaded(), rnd_loaded(), 0, 0, 0);
			end else if (r < 85) begin
				it = mk(FUNC_READ, $urandom_range(31), 0, 0, 0, 0, 0);
				if ($urandom_range(9) == 0) it.first_index = IDX_W'($urandom_range(1023));
			end else begin
				// noise: unused code, far indexes, random position bits
				it = mk(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom, $urandom, $urandom);
				if (it.func == FUNC_FACE &&
						!(pos_loaded[it.first_index] && pos_loaded[it.second_index] &&
						pos_loaded[it.third_index]))
					it.func = FUNC_READ;
			end
			send_item(it);
		end
		start <= 1'b0;

		r = 0;
		while (normal_queue.size() != 0 && r < 20000) begin
			@(posedge clk);
			r++;
		end
		repeat (600) @(posedge clk);
		if (fail_count == 0 && normal_queue.size() == 0)
			$display("PASS vertex_normal_accumulator");
		else
			$display("FAIL vertex_normal_accumulator");
		$finish;
	end

	// run limit: clearing pass plus ~470 items, faces among them slow, with idling, many times over
	initial begin : watchdog
		#8000000;
		$display("FAIL vertex_normal_accumulator");
		$finish;
	end
endmodule
